FILE: hw/rtl/fls_pkg.sv
// ----------------------------------------------------------------------------
// fls_pkg
// Shared types and constants for the free list slot allocator: field widths,
// operation and status codes, register indexes and the stack command/view.
// ----------------------------------------------------------------------------
package fls_pkg;

  localparam int IDX_W  = 10;  // slot index width
  localparam int CNT_W  = 11;  // stack depth and pool size width
  localparam int SLOT_W = 17;  // slot size width
  localparam int OFS_W  = 26;  // byte offset width
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int CFG_AW = 1;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_INIT    = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam logic [CFG_AW-1:0] REG_POOL_SIZE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SLOT_SIZE = 1'b1;

  // One stack operation per transfer; at most one of push, pop and init is set.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             init;
    logic [CNT_W-1:0] init_depth;
    logic [IDX_W-1:0] push_idx;
  } stk_cmd_t;

  // What the stack shows to the rest of the block in the current cycle.
  typedef struct packed {
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] depth_nxt;
    logic [IDX_W-1:0] top;
  } stk_view_t;

endpackage

FILE: hw/rtl/fls_stack.sv
// ----------------------------------------------------------------------------
// fls_stack
// LIFO stack of free slot indices with a registered top of stack and a
// prefetched entry below it, so that one push or pop completes per cycle.
// ----------------------------------------------------------------------------
module fls_stack
  import fls_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  stk_cmd_t  cmd,
  output stk_view_t view
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [IDX_W-1:0] mem [MAX_SLOTS];

  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] low_r, low_nxt;
  logic [IDX_W-1:0] tos_r, tos_nxt;
  logic [IDX_W-1:0] below_raw_r;
  logic [CNT_W-1:0] below_pos;
  logic [IDX_W-1:0] below;
  logic [CNT_W-1:0] rd_pos;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  // Positions under the lowest depth reached since the last init were never
  // written after it and still hold their identity value.
  assign below_pos = depth_r - CNT_W'(2);
  assign below     = (below_pos < low_r) ? below_pos[IDX_W-1:0] : below_raw_r;

  always_comb begin
    depth_nxt = depth_r;
    low_nxt   = low_r;
    tos_nxt   = tos_r;
    priority if (cmd.init) begin
      depth_nxt = cmd.init_depth;
      low_nxt   = cmd.init_depth;
      tos_nxt   = IDX_W'(cmd.init_depth - CNT_W'(1));
    end else if (cmd.push) begin
      depth_nxt = depth_r + CNT_W'(1);
      tos_nxt   = cmd.push_idx;
    end else if (cmd.pop) begin
      depth_nxt = depth_r - CNT_W'(1);
      tos_nxt   = below;
      low_nxt   = (depth_nxt < low_r) ? depth_nxt : low_r;
    end
  end

  assign rd_pos  = depth_nxt - CNT_W'(2);
  assign rd_addr = (depth_nxt < CNT_W'(2)) ? '0 : AW'(rd_pos);
  assign wr_addr = AW'(depth_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      low_r   <= '0;
    end else begin
      depth_r <= depth_nxt;
      low_r   <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
  end

  // A push writes the slot above the old top; the prefetch reads the slot two
  // under the new depth, which is never the slot written in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.push_idx;
    end
    below_raw_r <= mem[rd_addr];
  end

  assign view.depth     = depth_r;
  assign view.depth_nxt = depth_nxt;
  assign view.top       = tos_r;

endmodule

FILE: hw/rtl/fls_ctrl.sv
// ----------------------------------------------------------------------------
// fls_ctrl
// Request decoder: checks one request against the pool state and turns it
// into a status code and a stack command.
// ----------------------------------------------------------------------------
module fls_ctrl
  import fls_pkg::*;
#(
  parameter int MAX_SLOTS      = 1024,
  parameter int MAX_SLOT_BYTES = 65536
) (
  input  logic              fire,
  input  logic [OP_W-1:0]   opcode,
  input  logic [IDX_W-1:0]  release_index,
  input  logic [CNT_W-1:0]  depth,
  input  logic [CNT_W-1:0]  active_pool,
  input  logic [CNT_W-1:0]  pool_size,
  input  logic [SLOT_W-1:0] slot_size,
  output status_t           status,
  output stk_cmd_t          cmd
);

  logic bad_cfg;

  assign bad_cfg = (pool_size == '0) || (32'(pool_size) > 32'(MAX_SLOTS)) ||
                   (slot_size == '0) || (32'(slot_size) > 32'(MAX_SLOT_BYTES));

  always_comb begin
    status         = ST_OK;
    cmd.push       = 1'b0;
    cmd.pop        = 1'b0;
    cmd.init       = 1'b0;
    cmd.init_depth = pool_size;
    cmd.push_idx   = release_index;
    unique case (opcode_t'(opcode))
      OP_ACQUIRE: begin
        if (active_pool == '0 || depth == '0) begin
          status = ST_EMPTY;
        end else begin
          cmd.pop = fire;
        end
      end
      OP_RELEASE: begin
        if ({1'b0, release_index} >= active_pool) begin
          status = ST_RANGE;
        end else if (depth >= active_pool) begin
          status = ST_FULL;
        end else begin
          cmd.push = fire;
        end
      end
      OP_INIT: begin
        if (bad_cfg) begin
          status = ST_RANGE;
        end else begin
          cmd.init = fire;
        end
      end
      OP_NOP: begin
        status = ST_OK;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

endmodule

FILE: hw/rtl/free_list_slot_allocator.sv
// ----------------------------------------------------------------------------
// free_list_slot_allocator
// Fixed-slot buffer pool kept as a LIFO stack of free slot indices. Acquire
// pops a slot and reports its byte offset, release pushes one back, init
// refills the stack with every index of the configured pool.
//
//   Port group  Direction  Handshake       Contents
//   in_*        input      valid / stall   opcode, release index
//   out_*       output     valid / stall   status, slot index, byte offset,
//                                          free count
//   cfg_*       input      write enable    pool size, slot size registers
//
// Each request is decided in the cycle it is transferred and its result is
// registered, so one request can be taken every cycle unless the input is
// stalled; the stack keeps its top in a register and prefetches the entry
// under it from the memory read port. The input is stalled only while a
// result is held and the output is stalled. Reset is synchronous and active
// low; the stack memory is not cleared, since an init marks every position
// below the pool size as holding its own index.
// ----------------------------------------------------------------------------
module free_list_slot_allocator
  import fls_pkg::*;
#(
  parameter int MAX_SLOTS      = 1024,
  parameter int MAX_SLOT_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [IDX_W-1:0]   in_release_index,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [IDX_W-1:0]   out_slot_index,
  output logic [OFS_W-1:0]   out_byte_offset,
  output logic [CNT_W-1:0]   out_free_count,

  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [SLOT_W-1:0]  cfg_wdata
);

  // Configuration registers as last written, and the values captured from
  // them by the most recent accepted init.
  logic [CNT_W-1:0]  pool_size_r;
  logic [SLOT_W-1:0] slot_size_r;
  logic [CNT_W-1:0]  active_pool_r;
  logic [SLOT_W-1:0] active_slot_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_slot_index_r;
  logic [OFS_W-1:0]  out_byte_offset_r;
  logic [CNT_W-1:0]  out_free_count_r;

  logic              in_fire;
  logic              out_free;
  status_t           status;
  stk_cmd_t          cmd;
  stk_view_t         view;
  logic [IDX_W+SLOT_W-1:0] product;

  // The result register can take a new result when it is empty or when its
  // current result is transferred in this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign in_fire  = in_valid && out_free;

  fls_ctrl #(
    .MAX_SLOTS      (MAX_SLOTS),
    .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
  ) u_ctrl (
    .fire          (in_fire),
    .opcode        (in_opcode),
    .release_index (in_release_index),
    .depth         (view.depth),
    .active_pool   (active_pool_r),
    .pool_size     (pool_size_r),
    .slot_size     (slot_size_r),
    .status        (status),
    .cmd           (cmd)
  );

  fls_stack #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .view  (view)
  );

  // Byte offset of the slot on top of the stack; only used on a granted pop.
  assign product = {{SLOT_W{1'b0}}, view.top} * {{IDX_W{1'b0}}, active_slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r   <= CNT_W'(1024);
      slot_size_r   <= SLOT_W'(1024);
      active_pool_r <= '0;
      active_slot_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POOL_SIZE: pool_size_r <= cfg_wdata[CNT_W-1:0];
          REG_SLOT_SIZE: slot_size_r <= cfg_wdata;
          default:       pool_size_r <= pool_size_r;
        endcase
      end
      if (cmd.init) begin
        active_pool_r <= pool_size_r;
        active_slot_r <= slot_size_r;
      end
      if (out_free) begin
        out_valid_r <= in_valid;
      end
    end
  end

  // Result payload is loaded on every transfer in; it needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r      <= status;
      out_slot_index_r  <= cmd.pop ? view.top : '0;
      out_byte_offset_r <= cmd.pop ? product[OFS_W-1:0] : '0;
      out_free_count_r  <= view.depth_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_index_r;
  assign out_byte_offset = out_byte_offset_r;
  assign out_free_count  = out_free_count_r;

endmodule
